// File: rtl/bdll_pkg.sv
// shared types and codes for the bounded doubly linked list
package bdll_pkg;

   localparam int KEY_IO_WIDTH = 32;

   // command codes
   localparam logic [2:0] OP_INSERT     = 3'd0;
   localparam logic [2:0] OP_DEL_KEY    = 3'd1;
   localparam logic [2:0] OP_DEL_FIRST  = 3'd2;
   localparam logic [2:0] OP_DEL_LAST   = 3'd3;
   localparam logic [2:0] OP_DUMP       = 3'd4;

   // status codes
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [2:0]                     op;
      logic signed [KEY_IO_WIDTH-1:0] key;
   } req_item_type;

   typedef struct packed {
      logic [1:0]                     status;
      logic                           key_valid;
      logic signed [KEY_IO_WIDTH-1:0] key_out;
      logic                           last;
   } rsp_item_type;

   // write strobes into the node store
   typedef struct packed {
      logic key;
      logic next;
      logic prev;
   } node_we_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_INS_LINK,
      ST_WALK,
      ST_UNLINK,
      ST_DUMP,
      ST_RESP
   } state_type;

endpackage

// File: rtl/bdll_node_store.sv
// node store: key, next link and prev link memories with one shared registered read
module bdll_node_store #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [$clog2(CAPACITY)-1:0] rd_addr,
   input  bdll_pkg::node_we_type       we,
   input  logic [$clog2(CAPACITY)-1:0] link_waddr,
   input  logic [KEY_WIDTH-1:0]        key_wdata,
   input  logic [$clog2(CAPACITY)-1:0] next_wdata,
   input  logic [$clog2(CAPACITY)-1:0] prev_waddr,
   input  logic [$clog2(CAPACITY)-1:0] prev_wdata,
   output logic [KEY_WIDTH-1:0]        rd_key_ff,
   output logic [$clog2(CAPACITY)-1:0] rd_next_ff,
   output logic [$clog2(CAPACITY)-1:0] rd_prev_ff
);
   import bdll_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);

   logic [KEY_WIDTH-1:0] key_mem  [CAPACITY];
   logic [IDX_W-1:0]     next_mem [CAPACITY];
   logic [IDX_W-1:0]     prev_mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (we.key) begin
         key_mem[link_waddr] <= key_wdata;
      end
      if (we.next) begin
         next_mem[link_waddr] <= next_wdata;
      end
      if (we.prev) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff  <= key_mem[rd_addr];
         rd_next_ff <= next_mem[rd_addr];
         rd_prev_ff <= prev_mem[rd_addr];
      end
   end

endmodule

// File: rtl/bounded_doubly_linked_list_top.sv
// Bounded doubly linked list of keys: insert at front, delete by key, delete first or last, dump.
// One command is taken at a time; req_stall stays high until the command's last result item
// has been loaded into the output register, so the next command can enter while that item
// still waits on rsp_stall. Delete by key walks the list one node per cycle through the node
// store's single read port. Dump emits one element per cycle while the output side does not
// stall. Nodes that were never used come from a fill counter and freed nodes from a free stack
// memory, so no clearing pass follows reset.
module bounded_doubly_linked_list_top #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bdll_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bdll_pkg::rsp_item_type rsp_item
);
   import bdll_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type            state_ff, state_in;
   logic [2:0]           op_ff, op_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [1:0]           status_ff, status_in;
   logic                 pop_ff, pop_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic [IDX_W-1:0]     node_ff, node_in;
   logic [CNT_W-1:0]     walk_ff, walk_in;
   logic [CNT_W-1:0]     elem_cnt_ff, elem_cnt_in;
   logic [CNT_W-1:0]     free_cnt_ff, free_cnt_in;
   logic [CNT_W-1:0]     fresh_ff, fresh_in;
   logic                 rsp_valid_ff;
   rsp_item_type         rsp_item_ff;

   logic [IDX_W-1:0]     free_mem [CAPACITY];
   logic [IDX_W-1:0]     free_q_ff;
   logic                 free_rd_en;
   logic                 free_we;
   logic [CNT_W-1:0]     free_rd_cnt;

   logic                 node_rd_en;
   logic [IDX_W-1:0]     node_rd_addr;
   node_we_type          node_we;
   logic [IDX_W-1:0]     link_waddr;
   logic [IDX_W-1:0]     next_wdata;
   logic [IDX_W-1:0]     prev_waddr;
   logic [IDX_W-1:0]     prev_wdata;
   logic [KEY_WIDTH-1:0] rd_key;
   logic [IDX_W-1:0]     rd_next;
   logic [IDX_W-1:0]     rd_prev;

   logic                 req_accept;
   logic                 out_free;
   logic                 rsp_load;
   rsp_item_type         rsp_data;
   logic                 list_empty;
   logic                 list_full;
   logic                 key_hit;
   logic [CNT_W-1:0]     walk_nxt;
   logic                 walk_end;
   logic [IDX_W-1:0]     new_node;
   logic [63:0]          req_key_ext;
   logic [63:0]          rd_key_ext;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign list_empty  = (elem_cnt_ff == '0);
   assign list_full   = (elem_cnt_ff == CNT_W'(CAPACITY));
   assign key_hit     = (rd_key == key_ff);
   assign walk_nxt    = walk_ff + CNT_W'(1);
   assign walk_end    = (walk_nxt == elem_cnt_ff);
   assign new_node    = pop_ff ? free_q_ff : node_ff;
   assign free_rd_cnt = free_cnt_ff - CNT_W'(1);
   assign req_key_ext = 64'(req_item.key);
   assign rd_key_ext  = 64'($signed(rd_key));

   bdll_node_store #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_node_store (
      .clock      (clock),
      .rd_en      (node_rd_en),
      .rd_addr    (node_rd_addr),
      .we         (node_we),
      .link_waddr (link_waddr),
      .key_wdata  (key_ff),
      .next_wdata (next_wdata),
      .prev_waddr (prev_waddr),
      .prev_wdata (prev_wdata),
      .rd_key_ff  (rd_key),
      .rd_next_ff (rd_next),
      .rd_prev_ff (rd_prev)
   );

   // free stack of released nodes
   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[free_cnt_ff[IDX_W-1:0]] <= node_ff;
      end
      if (free_rd_en) begin
         free_q_ff <= free_mem[free_rd_cnt[IDX_W-1:0]];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (op_ff)
               OP_INSERT:  state_in = list_full ? ST_RESP : ST_INS_LINK;
               OP_DEL_KEY: state_in = list_empty ? ST_RESP : ST_WALK;
               OP_DEL_FIRST, OP_DEL_LAST: state_in = list_empty ? ST_RESP : ST_UNLINK;
               OP_DUMP:    state_in = list_empty ? ST_RESP : ST_DUMP;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_INS_LINK: state_in = ST_RESP;
         ST_WALK: begin
            if (key_hit) begin
               state_in = ST_UNLINK;
            end else if (walk_end) begin
               state_in = ST_RESP;
            end
         end
         ST_UNLINK: state_in = ST_RESP;
         ST_DUMP: begin
            if (out_free && walk_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in        = op_ff;
      key_in       = key_ff;
      status_in    = status_ff;
      pop_in       = pop_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      node_in      = node_ff;
      walk_in      = walk_ff;
      elem_cnt_in  = elem_cnt_ff;
      free_cnt_in  = free_cnt_ff;
      fresh_in     = fresh_ff;
      free_rd_en   = 1'b0;
      free_we      = 1'b0;
      node_rd_en   = 1'b0;
      node_rd_addr = head_ff;
      node_we      = '0;
      link_waddr   = new_node;
      next_wdata   = head_ff;
      prev_waddr   = head_ff;
      prev_wdata   = new_node;
      rsp_load     = 1'b0;
      rsp_data     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in  = req_item.op;
               key_in = req_key_ext[KEY_WIDTH-1:0];
            end
         end
         ST_DECODE: begin
            status_in = STATUS_DONE;
            walk_in   = '0;
            unique case (op_ff)
               OP_INSERT: begin
                  if (list_full) begin
                     status_in = STATUS_FULL;
                  end else if (free_cnt_ff != '0) begin
                     free_rd_en  = 1'b1;
                     pop_in      = 1'b1;
                     free_cnt_in = free_rd_cnt;
                  end else begin
                     pop_in   = 1'b0;
                     node_in  = fresh_ff[IDX_W-1:0];
                     fresh_in = fresh_ff + CNT_W'(1);
                  end
               end
               OP_DEL_KEY, OP_DUMP: begin
                  if (list_empty) begin
                     status_in = STATUS_NOT_FOUND;
                  end else begin
                     node_rd_en   = 1'b1;
                     node_rd_addr = head_ff;
                  end
               end
               OP_DEL_FIRST, OP_DEL_LAST: begin
                  if (list_empty) begin
                     status_in = STATUS_NOT_FOUND;
                  end else begin
                     node_rd_en   = 1'b1;
                     node_rd_addr = (op_ff == OP_DEL_FIRST) ? head_ff : tail_ff;
                     node_in      = (op_ff == OP_DEL_FIRST) ? head_ff : tail_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_INS_LINK: begin
            // head's prev is unused; the old head's prev is written, or the new node's if empty
            node_we.key  = 1'b1;
            node_we.next = 1'b1;
            node_we.prev = 1'b1;
            link_waddr   = new_node;
            next_wdata   = list_empty ? new_node : head_ff;
            prev_waddr   = list_empty ? new_node : head_ff;
            prev_wdata   = new_node;
            head_in      = new_node;
            if (list_empty) begin
               tail_in = new_node;
            end
            elem_cnt_in  = elem_cnt_ff + CNT_W'(1);
         end
         ST_WALK: begin
            if (key_hit) begin
               // re-read the matching node for both its links
               node_rd_en   = 1'b1;
               node_rd_addr = node_ff;
            end else if (walk_end) begin
               status_in = STATUS_NOT_FOUND;
            end else begin
               node_rd_en   = 1'b1;
               node_rd_addr = rd_next;
               node_in      = rd_next;
               walk_in      = walk_nxt;
            end
         end
         ST_UNLINK: begin
            if (node_ff == head_ff) begin
               head_in = rd_next;
            end else begin
               node_we.next = 1'b1;
               link_waddr   = rd_prev;
               next_wdata   = rd_next;
            end
            if (node_ff == tail_ff) begin
               tail_in = rd_prev;
            end else begin
               node_we.prev = 1'b1;
               prev_waddr   = rd_next;
               prev_wdata   = rd_prev;
            end
            free_we     = 1'b1;
            free_cnt_in = free_cnt_ff + CNT_W'(1);
            elem_cnt_in = elem_cnt_ff - CNT_W'(1);
         end
         ST_DUMP: begin
            if (out_free) begin
               rsp_load           = 1'b1;
               rsp_data.status    = STATUS_DONE;
               rsp_data.key_valid = 1'b1;
               rsp_data.key_out   = rd_key_ext[KEY_IO_WIDTH-1:0];
               rsp_data.last      = walk_end;
               if (!walk_end) begin
                  node_rd_en   = 1'b1;
                  node_rd_addr = rd_next;
                  walk_in      = walk_nxt;
               end
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_load        = 1'b1;
               rsp_data.status = status_ff;
               rsp_data.last   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // during a key walk node_ff tracks the node whose data is on the read port
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ff     <= '0;
         tail_ff     <= '0;
         elem_cnt_ff <= '0;
         free_cnt_ff <= '0;
         fresh_ff    <= '0;
         pop_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         elem_cnt_ff <= elem_cnt_in;
         free_cnt_ff <= free_cnt_in;
         fresh_ff    <= fresh_in;
         pop_ff      <= pop_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      node_ff   <= (state_ff == ST_DECODE && op_ff == OP_DEL_KEY) ? head_ff : node_in;
      walk_ff   <= walk_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_item_ff <= rsp_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // every node is either linked, on the free stack or never handed out
   a_node_balance: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |->
         ({1'b0, elem_cnt_ff} + {1'b0, free_cnt_ff}) == {1'b0, fresh_ff})
      else $error("node accounting out of balance");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      elem_cnt_ff <= CNT_W'(CAPACITY))
      else $error("element count beyond capacity");

   a_no_link_when_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INS_LINK |-> !list_full)
      else $error("insert linking into a full list");

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_DECODE)
      else $error("accepted item not decoded");

endmodule

// File: tb/sv/testbench.sv
// testbench for the bounded doubly linked list: queue-fed driver, checking monitor
module testbench;
   import bdll_pkg::*;

   localparam int LIST_CAPACITY = 64;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int DRAIN_CYCLES  = 2 * LIST_CAPACITY + 20;
   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   // pending commands, the modelled list (front at index 0) and the replies owed
   req_item_type         pending_cmds[$];
   logic signed [31:0]   list_keys[$];
   rsp_item_type         replies_due[$];
   logic signed [31:0]   key_pool[8];

   int             cycle_count = 0;
   int             error_count = 0;
   int             cmds_taken = 0;
   int             replies_checked = 0;
   int             dump_count = 0;
   int             full_drops = 0;
   int             not_found_count = 0;
   int             longest_list = 0;
   int             burst_left = 1;
   int             gap_left = 0;
   int             stall_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   rsp_item_type   want;

   bounded_doubly_linked_list_top #(
      .CAPACITY  (LIST_CAPACITY),
      .KEY_WIDTH (32)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_item_type make_reply(logic [1:0] status, logic key_valid,
                                               logic signed [31:0] key_out, logic last);
      rsp_item_type r;
      r.status    = status;
      r.key_valid = key_valid;
      r.key_out   = key_out;
      r.last      = last;
      return r;
   endfunction

   // update the list for one accepted command and queue the replies it owes
   task automatic apply_command(input req_item_type cmd);
      int hit;
      int n;
      hit = -1;
      n = list_keys.size();
      case (cmd.op)
         OP_INSERT: begin
            if (n >= LIST_CAPACITY) begin
               replies_due.push_back(make_reply(STATUS_FULL, 1'b0, '0, 1'b1));
               full_drops++;
            end else begin
               list_keys.push_front(cmd.key);
               replies_due.push_back(make_reply(STATUS_DONE, 1'b0, '0, 1'b1));
               if (n + 1 > longest_list) longest_list = n + 1;
            end
         end
         OP_DEL_KEY: begin
            for (int i = 0; i < n; i++) begin
               if (hit < 0 && list_keys[i] == cmd.key) hit = i;
            end
            if (hit < 0) begin
               replies_due.push_back(make_reply(STATUS_NOT_FOUND, 1'b0, '0, 1'b1));
               not_found_count++;
            end else begin
               list_keys.delete(hit);
               replies_due.push_back(make_reply(STATUS_DONE, 1'b0, '0, 1'b1));
            end
         end
         OP_DEL_FIRST, OP_DEL_LAST: begin
            if (n == 0) begin
               replies_due.push_back(make_reply(STATUS_NOT_FOUND, 1'b0, '0, 1'b1));
               not_found_count++;
            end else begin
               if (cmd.op == OP_DEL_FIRST) void'(list_keys.pop_front());
               else void'(list_keys.pop_back());
               replies_due.push_back(make_reply(STATUS_DONE, 1'b0, '0, 1'b1));
            end
         end
         OP_DUMP: begin
            dump_count++;
            if (n == 0) begin
               replies_due.push_back(make_reply(STATUS_NOT_FOUND, 1'b0, '0, 1'b1));
               not_found_count++;
            end else begin
               for (int i = 0; i < n; i++)
                  replies_due.push_back(make_reply(STATUS_DONE, 1'b1, list_keys[i], i == n - 1));
            end
         end
         default: ;   // unused op codes: no reply
      endcase
   endtask

   task automatic queue_cmd(input logic [2:0] op, input logic signed [31:0] key);
      req_item_type c;
      c.op  = op;
      c.key = key;
      pending_cmds.push_back(c);
   endtask

   // mostly keys from a small pool so deletes by key find something
   function automatic logic signed [31:0] pick_key();
      if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   task automatic queue_random_cmd();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)      queue_cmd(OP_INSERT, pick_key());
      else if (r < 60) queue_cmd(OP_DEL_KEY, pick_key());
      else if (r < 70) queue_cmd(OP_DEL_FIRST, $urandom);
      else if (r < 80) queue_cmd(OP_DEL_LAST, $urandom);
      else if (r < 95) queue_cmd(OP_DUMP, $urandom);
      else queue_cmd(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), $urandom);
   endtask

   // driver: bursts of random length with random gaps, payload held while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_command(req_item);
            cmds_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 || pending_cmds.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               req_item  <= pending_cmds.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 30);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // receiver stall pattern, switching at random among four modes
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(20, 120);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= ((cycle_count % 5) < 2);
      endcase
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (replies_due.size() == 0) begin
            $error("unexpected result item: status %0d key_valid %0b key_out %0d last %0b",
                   rsp_item.status, rsp_item.key_valid, rsp_item.key_out, rsp_item.last);
            error_count++;
         end else begin
            want = replies_due.pop_front();
            replies_checked++;
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_item.status);
               error_count++;
            end
            if (rsp_item.key_valid !== want.key_valid) begin
               $error("key_valid: expected %0b, got %0b", want.key_valid, rsp_item.key_valid);
               error_count++;
            end
            if (rsp_item.key_out !== want.key_out) begin
               $error("key_out: expected %h, got %h", want.key_out, rsp_item.key_out);
               error_count++;
            end
            if (rsp_item.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_item.last);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d result items still owed", replies_due.size());
         $display("bounded_doubly_linked_list_top test failed");
         $finish;
      end
   end

   initial begin
      key_pool[0] = 32'sh8000_0000;
      key_pool[1] = 32'sh7fff_ffff;
      key_pool[2] = 32'sh0000_0000;
      key_pool[3] = -32'sd1;
      for (int i = 4; i < 8; i++) key_pool[i] = $urandom;

      // directed: empty list, key extremes, hits at front, middle and back, duplicates
      queue_cmd(OP_DUMP, 32'sh0);
      queue_cmd(OP_DEL_FIRST, 32'sh0);
      queue_cmd(OP_DEL_LAST, 32'sh0);
      queue_cmd(OP_DEL_KEY, 32'sh0);
      queue_cmd(OP_INSERT, 32'sh8000_0000);
      queue_cmd(OP_INSERT, 32'sh7fff_ffff);
      queue_cmd(OP_INSERT, 32'sh0);
      queue_cmd(OP_INSERT, -32'sd1);
      queue_cmd(OP_INSERT, 32'sh1234_5678);
      queue_cmd(OP_DUMP, 32'sh0);
      queue_cmd(OP_DEL_KEY, 32'sh55aa_55aa);
      queue_cmd(OP_DEL_KEY, 32'sh0);
      queue_cmd(OP_DEL_KEY, 32'sh8000_0000);
      queue_cmd(OP_DEL_KEY, 32'sh1234_5678);
      queue_cmd(OP_INSERT, -32'sd1);
      queue_cmd(OP_DEL_KEY, -32'sd1);
      queue_cmd(OP_DUMP, -32'sd1);
      for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++) queue_cmd(3'(op), $urandom);
      queue_cmd(OP_DEL_FIRST, -32'sd1);
      queue_cmd(OP_DEL_LAST, -32'sd1);
      queue_cmd(OP_DUMP, 32'sh0);

      // random mix, then fill past capacity, dump the full list and delete from it
      repeat (70) queue_random_cmd();
      repeat (LIST_CAPACITY + 4) queue_cmd(OP_INSERT, pick_key());
      queue_cmd(OP_DUMP, $urandom);
      repeat (LIST_CAPACITY + 6) begin
         case ($urandom_range(0, 2))
            0:       queue_cmd(OP_DEL_FIRST, $urandom);
            1:       queue_cmd(OP_DEL_LAST, $urandom);
            default: queue_cmd(OP_DEL_KEY, pick_key());
         endcase
         if ($urandom_range(0, 15) == 0) queue_cmd(OP_DUMP, $urandom);
      end
      repeat (60) queue_random_cmd();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_cmds.size() != 0 || req_valid || replies_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d commands taken, %0d dumps, %0d full-list drops, %0d not-found replies",
               cmds_taken, dump_count, full_drops, not_found_count);
      $display("%0d result items checked, longest list %0d of %0d",
               replies_checked, longest_list, LIST_CAPACITY);
      if (error_count == 0) begin
         $display("bounded_doubly_linked_list_top test passed");
      end else begin
         $display("bounded_doubly_linked_list_top test failed");
      end
      $finish;
   end

endmodule
